// ===== rtl/sparse_matrix_vector_multiply_unit_macros.svh =====
// Assertion macros for the sparse matrix-vector multiply unit.
// Expects signals clk and rst_n in the scope of each use.
`ifndef SPARSE_MATRIX_VECTOR_MULTIPLY_UNIT_MACROS_SVH
`define SPARSE_MATRIX_VECTOR_MULTIPLY_UNIT_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define SMV_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled during reset.
`define SMV_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/smv_pkg.sv =====
// Shared types and constants for the sparse matrix-vector multiply unit.
// No dependencies.
`timescale 1ns / 1ps

package smv_pkg;

  localparam int unsigned SMV_VECTOR_DEPTH_DEF = 1024;
  localparam int unsigned SMV_ROW_LIMIT        = 65536;

  localparam int SMV_COL_W   = 10;
  localparam int SMV_ROW_W   = 16;
  localparam int SMV_VAL_W   = 32;
  localparam int SMV_ACC_W   = 48;
  localparam int SMV_PADDR_W = 4;
  localparam int SMV_PDATA_W = 32;

  // action codes
  localparam logic [1:0] ACT_LOAD_X  = 2'd0;
  localparam logic [1:0] ACT_LOAD_Y  = 2'd1;
  localparam logic [1:0] ACT_NONZERO = 2'd2;

  // register indexes (byte address / 4)
  localparam logic [1:0] REG_SPLIT_MODE   = 2'd0;
  localparam logic [1:0] REG_SPLIT_COLUMN = 2'd1;
  localparam logic [1:0] REG_PIVOT_VALUE  = 2'd2;

  typedef struct packed {
    logic [1:0]                  action;
    logic [SMV_COL_W-1:0]        column;
    logic [SMV_ROW_W-1:0]        row;
    logic signed [SMV_VAL_W-1:0] value;
    logic                        row_end;
  } in_item_t;

  typedef struct packed {
    logic [SMV_ROW_W-1:0]        result_row;
    logic signed [SMV_ACC_W-1:0] row_sum;
    logic                        saturated;
  } out_item_t;

endpackage

// ===== rtl/sparse_matrix_vector_multiply_unit.sv =====
// Sparse matrix-vector multiply unit: x/y vector stores, Q16.16 MAC, saturating row sums.
// Depends on smv_pkg and sparse_matrix_vector_multiply_unit_macros.svh.
// A row_end nonzero's sum goes through the store read and stage 1 registers, the stage 2
// registers (multiply) and the result register (accumulate) to out_*, strobed by out_valid.
// Throughput: one item per cycle, busy stays low; results cannot be stalled.
// Reset (rst_n, synchronous) clears config, accumulator and valids; vector stores are not.
`timescale 1ns / 1ps

module sparse_matrix_vector_multiply_unit #(
  parameter int unsigned VECTOR_DEPTH = smv_pkg::SMV_VECTOR_DEPTH_DEF
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              start,
  output logic                              busy,
  input  smv_pkg::in_item_t                 in_item,
  output logic                              out_valid,
  output smv_pkg::out_item_t                out_item,
  input  logic                              psel,
  input  logic                              penable,
  input  logic                              pwrite,
  input  logic [smv_pkg::SMV_PADDR_W-1:0]   paddr,
  input  logic [smv_pkg::SMV_PDATA_W-1:0]   pwdata,
  output logic [smv_pkg::SMV_PDATA_W-1:0]   prdata,
  output logic                              pready
);
  import smv_pkg::*;

`include "sparse_matrix_vector_multiply_unit_macros.svh"

  localparam int AW = (VECTOR_DEPTH > 1) ? $clog2(VECTOR_DEPTH) : 1;

  // vector source select
  localparam logic [1:0] SEL_X     = 2'd0;
  localparam logic [1:0] SEL_Y     = 2'd1;
  localparam logic [1:0] SEL_PIVOT = 2'd2;
  localparam logic [1:0] SEL_ZERO  = 2'd3;

  // ---------------- configuration ----------------
  logic                        split_mode_r;
  logic [SMV_COL_W-1:0]        split_column_r;
  logic signed [SMV_VAL_W-1:0] pivot_value_r;
  logic                        cfg_wr;
  logic [1:0]                  cfg_idx;

  assign pready  = 1'b1;
  assign cfg_wr  = psel & penable & pwrite & pready;
  assign cfg_idx = paddr[3:2];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      split_mode_r   <= 1'b0;
      split_column_r <= '0;
      pivot_value_r  <= '0;
    end else if (cfg_wr) begin
      case (cfg_idx)
        REG_SPLIT_MODE:   split_mode_r   <= pwdata[0];
        REG_SPLIT_COLUMN: split_column_r <= pwdata[SMV_COL_W-1:0];
        REG_PIVOT_VALUE:  pivot_value_r  <= pwdata;
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (cfg_idx)
      REG_SPLIT_MODE:   prdata = {{(SMV_PDATA_W-1){1'b0}}, split_mode_r};
      REG_SPLIT_COLUMN: prdata = {{(SMV_PDATA_W-SMV_COL_W){1'b0}}, split_column_r};
      REG_PIVOT_VALUE:  prdata = pivot_value_r;
      default:          prdata = '0;
    endcase
  end

  // ---------------- input decode and store access ----------------
  logic                     accept;
  logic                     in_range;
  logic                     is_nz;
  logic [AW+SMV_COL_W-1:0]  col_ext;
  logic [AW-1:0]            addr;
  logic [1:0]               sel_nxt;

  assign busy     = 1'b0;
  assign accept   = start & ~busy;
  assign is_nz    = (in_item.action == ACT_NONZERO);
  assign in_range = (32'(in_item.column) < VECTOR_DEPTH);
  assign col_ext  = {{AW{1'b0}}, in_item.column};
  assign addr     = col_ext[AW-1:0];

  always_comb begin
    if (split_mode_r && in_item.column == split_column_r) begin
      sel_nxt = SEL_PIVOT;
    end else if (!in_range) begin
      sel_nxt = SEL_ZERO;
    end else if (split_mode_r && in_item.column > split_column_r) begin
      sel_nxt = SEL_Y;
    end else begin
      sel_nxt = SEL_X;
    end
  end

  logic [SMV_VAL_W-1:0] x_mem [VECTOR_DEPTH];
  logic [SMV_VAL_W-1:0] y_mem [VECTOR_DEPTH];
  logic [SMV_VAL_W-1:0] x_rd_r;
  logic [SMV_VAL_W-1:0] y_rd_r;

  // a load is written before any later nonzero reads the store, so no forwarding
  always_ff @(posedge clk) begin
    if (accept && in_range && in_item.action == ACT_LOAD_X) begin
      x_mem[addr] <= in_item.value;
    end
    if (accept && in_range && is_nz) begin
      x_rd_r <= x_mem[addr];
    end
  end

  always_ff @(posedge clk) begin
    if (accept && in_range && in_item.action == ACT_LOAD_Y) begin
      y_mem[addr] <= in_item.value;
    end
    if (accept && in_range && is_nz) begin
      y_rd_r <= y_mem[addr];
    end
  end

  // ---------------- stage 1: select vector value, multiply ----------------
  logic                        s1_v_r;
  logic [1:0]                  s1_sel_r;
  logic signed [SMV_VAL_W-1:0] s1_val_r;
  logic [SMV_ROW_W-1:0]        s1_row_r;
  logic                        s1_last_r;
  logic signed [SMV_VAL_W-1:0] vec;
  logic signed [2*SMV_VAL_W-1:0] prod_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
    end else begin
      s1_v_r <= accept & is_nz;
    end
  end

  always_ff @(posedge clk) begin
    if (accept && is_nz) begin
      s1_sel_r  <= sel_nxt;
      s1_val_r  <= in_item.value;
      s1_row_r  <= in_item.row;
      s1_last_r <= in_item.row_end;
    end
  end

  always_comb begin
    case (s1_sel_r)
      SEL_X:     vec = x_rd_r;
      SEL_Y:     vec = y_rd_r;
      SEL_PIVOT: vec = pivot_value_r;
      default:   vec = '0;
    endcase
  end

  assign prod_nxt = s1_val_r * vec;

  // ---------------- stage 2: truncate, accumulate, saturate ----------------
  logic                          s2_v_r;
  logic signed [2*SMV_VAL_W-1:0] s2_prod_r;
  logic [SMV_ROW_W-1:0]          s2_row_r;
  logic                          s2_last_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_v_r <= 1'b0;
    end else begin
      s2_v_r <= s1_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_v_r) begin
      s2_prod_r <= prod_nxt;
      s2_row_r  <= s1_row_r;
      s2_last_r <= s1_last_r;
    end
  end

  logic signed [2*SMV_VAL_W-1:0] prod_sh;
  logic signed [SMV_ACC_W-1:0]   prod_q;
  logic signed [SMV_ACC_W:0]     sum_wide;
  logic signed [SMV_ACC_W-1:0]   sum_sat;
  logic                          ovf;
  logic signed [SMV_ACC_W-1:0]   acc_r;
  logic signed [SMV_ACC_W-1:0]   acc_nxt;
  logic                          sat_r;
  logic                          sat_nxt;
  logic [SMV_ROW_W-1:0]          row_mod;

  // arithmetic shift is the floor; the Q16.16 product fits 48 bits after it
  assign prod_sh  = s2_prod_r >>> 16;
  assign prod_q   = prod_sh[SMV_ACC_W-1:0];
  assign sum_wide = {acc_r[SMV_ACC_W-1], acc_r} + {prod_q[SMV_ACC_W-1], prod_q};
  assign ovf      = sum_wide[SMV_ACC_W] ^ sum_wide[SMV_ACC_W-1];
  assign row_mod  = SMV_ROW_W'(32'(s2_row_r) % SMV_ROW_LIMIT);

  always_comb begin
    if (!ovf) begin
      sum_sat = sum_wide[SMV_ACC_W-1:0];
    end else if (sum_wide[SMV_ACC_W]) begin
      sum_sat = {1'b1, {(SMV_ACC_W-1){1'b0}}};
    end else begin
      sum_sat = {1'b0, {(SMV_ACC_W-1){1'b1}}};
    end
  end

  assign acc_nxt = sum_sat;
  assign sat_nxt = sat_r | ovf;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      acc_r <= '0;
      sat_r <= 1'b0;
    end else if (s2_v_r) begin
      if (s2_last_r) begin
        acc_r <= '0;
        sat_r <= 1'b0;
      end else begin
        acc_r <= acc_nxt;
        sat_r <= sat_nxt;
      end
    end
  end

  // ---------------- result register ----------------
  logic      out_valid_r;
  out_item_t out_item_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= s2_v_r & s2_last_r;
    end
  end

  always_ff @(posedge clk) begin
    if (s2_v_r && s2_last_r) begin
      out_item_r.result_row <= row_mod;
      out_item_r.row_sum    <= acc_nxt;
      out_item_r.saturated  <= sat_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_item  = out_item_r;

  // ---------------- assertions ----------------
  `SMV_ASSERT_NEXT(a_row_end_emits, s2_v_r && s2_last_r, out_valid_r,
                   "row end did not produce a result")
  `SMV_ASSERT_NEXT(a_mid_row_silent, !(s2_v_r && s2_last_r), !out_valid_r,
                   "result strobe without a row end")
  `SMV_ASSERT_NEXT(a_acc_cleared, s2_v_r && s2_last_r, acc_r == '0 && !sat_r,
                   "accumulator not cleared after row end")
  `SMV_ASSERT_NOW(a_nz_pipe, s2_v_r, $past(s1_v_r),
                  "stage 2 valid without stage 1 transfer")

endmodule

// ===== dv/smv_row_sum_checker.sv =====
`timescale 1ns / 1ps
// Row-sum checker for the sparse matrix-vector multiply unit: mirrors the vector stores,
// the config registers and the saturating Q32.16 accumulator, and compares each row sum.
// Depends on smv_pkg.

module smv_row_sum_checker (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            start,
  input  logic                            busy,
  input  smv_pkg::in_item_t               in_item,
  input  logic                            out_valid,
  input  smv_pkg::out_item_t              out_item,
  input  logic                            psel,
  input  logic                            penable,
  input  logic                            pwrite,
  input  logic                            pready,
  input  logic [smv_pkg::SMV_PADDR_W-1:0] paddr,
  input  logic [smv_pkg::SMV_PDATA_W-1:0] pwdata,
  output int unsigned                     sums_pending,
  output int unsigned                     mismatch_count
);
  import smv_pkg::*;

  localparam longint SUM_MAX = 64'sh0000_7FFF_FFFF_FFFF;
  localparam longint SUM_MIN = -SUM_MAX - 1;

  logic [SMV_VAL_W-1:0] x_vec [SMV_VECTOR_DEPTH_DEF];
  logic [SMV_VAL_W-1:0] y_vec [SMV_VECTOR_DEPTH_DEF];
  longint               row_acc;
  logic                 row_sat;
  logic                 split_on;
  logic [SMV_COL_W-1:0] split_col;
  logic [SMV_VAL_W-1:0] pivot;
  out_item_t            expected_sums [$];

  task automatic report_mismatch(input string what);
    mismatch_count++;
    $display("[%0t] row sum mismatch: %s", $time, what);
  endtask

  function automatic longint vector_value(input logic [SMV_COL_W-1:0] col);
    if (split_on && col == split_col) return longint'($signed(pivot));
    if (split_on && col > split_col) return longint'($signed(y_vec[col]));
    return longint'($signed(x_vec[col]));
  endfunction

  task automatic apply_reg_write(input logic [1:0] idx, input logic [SMV_PDATA_W-1:0] data);
    case (idx)
      REG_SPLIT_MODE:   split_on = data[0];
      REG_SPLIT_COLUMN: split_col = data[SMV_COL_W-1:0];
      REG_PIVOT_VALUE:  pivot = data[SMV_VAL_W-1:0];
      default: ;
    endcase
  endtask

  // Accumulate one transfer; a row_end nonzero queues the row sum it should produce.
  task automatic accumulate_item(input in_item_t it);
    longint    prod;
    longint    total;
    out_item_t sum_item;
    case (it.action)
      ACT_LOAD_X: x_vec[it.column] = it.value;
      ACT_LOAD_Y: y_vec[it.column] = it.value;
      ACT_NONZERO: begin
        // exact 64-bit product, then floor to Q32.16
        prod = (longint'($signed(it.value)) * vector_value(it.column)) >>> 16;
        total = row_acc + prod;
        if (total > SUM_MAX) begin
          total = SUM_MAX;
          row_sat = 1'b1;
        end else if (total < SUM_MIN) begin
          total = SUM_MIN;
          row_sat = 1'b1;
        end
        row_acc = total;
        if (it.row_end) begin
          sum_item.result_row = it.row;
          sum_item.row_sum = total[SMV_ACC_W-1:0];
          sum_item.saturated = row_sat;
          expected_sums = {expected_sums, sum_item};
          row_acc = 0;
          row_sat = 1'b0;
        end
      end
      default: ;
    endcase
  endtask

  task automatic check_row_sum(input out_item_t got);
    out_item_t want;
    if (expected_sums.size() == 0) begin
      report_mismatch($sformatf("unexpected sum for row %0d", got.result_row));
      return;
    end
    want = expected_sums.pop_front();
    if (got.result_row !== want.result_row)
      report_mismatch($sformatf("result_row %0d, expected %0d",
                                got.result_row, want.result_row));
    if (got.row_sum !== want.row_sum)
      report_mismatch($sformatf("row %0d: row_sum %0d, expected %0d", want.result_row,
                                $signed(got.row_sum), $signed(want.row_sum)));
    if (got.saturated !== want.saturated)
      report_mismatch($sformatf("row %0d: saturated %b, expected %b", want.result_row,
                                got.saturated, want.saturated));
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      row_acc = 0;
      row_sat = 1'b0;
      split_on = 1'b0;
      split_col = '0;
      pivot = '0;
      mismatch_count = 0;
      expected_sums.delete();
    end else begin
      if (psel && penable && pwrite && pready)
        apply_reg_write(paddr[SMV_PADDR_W-1:2], pwdata);
      if (out_valid)
        check_row_sum(out_item);
      if (start && !busy)
        accumulate_item(in_item);
    end
    sums_pending <= expected_sums.size();
  end

endmodule

// ===== dv/tb_top.sv =====
`timescale 1ns / 1ps
// Testbench top for the sparse matrix-vector multiply unit: clock, reset, APB register
// writes and item stimulus; row sums are checked in smv_row_sum_checker.
// Depends on smv_pkg, sparse_matrix_vector_multiply_unit and smv_row_sum_checker.

module tb_top;
  import smv_pkg::*;

  localparam logic [1:0]  ACT_UNUSED    = 2'd3;
  localparam int unsigned RANDOM_ITEMS  = 1150;
  localparam int unsigned CALM_TAIL     = 150;
  localparam int unsigned DRAIN_LIMIT   = 500;
  localparam int unsigned SETTLE_CYCLES = 8;

  logic                   clk = 1'b0;
  logic                   rst_n = 1'b0;
  logic                   start = 1'b0;
  logic                   busy;
  in_item_t               in_item = '0;
  logic                   out_valid;
  out_item_t              out_item;
  logic                   psel = 1'b0;
  logic                   penable = 1'b0;
  logic                   pwrite = 1'b0;
  logic [SMV_PADDR_W-1:0] paddr = '0;
  logic [SMV_PDATA_W-1:0] pwdata = '0;
  logic [SMV_PDATA_W-1:0] prdata;
  logic                   pready;
  int unsigned            sums_pending;
  int unsigned            mismatch_count;

  // stimulus-side view: which entries may be read, and how columns map to stores
  bit                   x_loaded [SMV_VECTOR_DEPTH_DEF];
  bit                   y_loaded [SMV_VECTOR_DEPTH_DEF];
  bit                   split_on = 1'b0;
  logic [SMV_COL_W-1:0] split_col = '0;
  logic [SMV_COL_W-1:0] window_base = '0;
  logic [SMV_ROW_W-1:0] next_row = '0;
  int unsigned          items_sent = 0;
  int unsigned          item_goal = RANDOM_ITEMS + 40;
  int unsigned          idle_pct = 30;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  sparse_matrix_vector_multiply_unit dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .in_item   (in_item),
    .out_valid (out_valid),
    .out_item  (out_item),
    .psel      (psel),
    .penable   (penable),
    .pwrite    (pwrite),
    .paddr     (paddr),
    .pwdata    (pwdata),
    .prdata    (prdata),
    .pready    (pready)
  );

  smv_row_sum_checker row_sum_check (
    .clk            (clk),
    .rst_n          (rst_n),
    .start          (start),
    .busy           (busy),
    .in_item        (in_item),
    .out_valid      (out_valid),
    .out_item       (out_item),
    .psel           (psel),
    .penable        (penable),
    .pwrite         (pwrite),
    .pready         (pready),
    .paddr          (paddr),
    .pwdata         (pwdata),
    .sums_pending   (sums_pending),
    .mismatch_count (mismatch_count)
  );

  function automatic in_item_t make_item(input logic [1:0] act,
                                         input logic [SMV_COL_W-1:0] col,
                                         input logic [SMV_ROW_W-1:0] row,
                                         input logic [SMV_VAL_W-1:0] val,
                                         input logic last);
    in_item_t it;
    it.action = act;
    it.column = col;
    it.row = row;
    it.value = val;
    it.row_end = last;
    return it;
  endfunction

  function automatic bit vec_ready(input logic [SMV_COL_W-1:0] col);
    if (split_on && col == split_col) return 1'b1;
    if (split_on && col > split_col) return y_loaded[col];
    return x_loaded[col];
  endfunction

  function automatic logic [1:0] store_for(input logic [SMV_COL_W-1:0] col);
    return (split_on && col > split_col) ? ACT_LOAD_Y : ACT_LOAD_X;
  endfunction

  function automatic logic [SMV_VAL_W-1:0] pick_value();
    case ($urandom_range(9))
      0: return 32'h8000_0000;
      1: return 32'h7FFF_FFFF;
      2: return SMV_VAL_W'(int'($urandom_range(262143)) - 131072);
      3: return SMV_VAL_W'(int'($urandom_range(2)) - 1);
      default: return $urandom();
    endcase
  endfunction

  function automatic logic [SMV_COL_W-1:0] pick_column();
    case ($urandom_range(9))
      0: return '0;
      1: return '1;
      2: return split_col;
      3, 4: return SMV_COL_W'($urandom());
      default: return window_base + SMV_COL_W'($urandom_range(31));
    endcase
  endfunction

  // Called at a rising edge; returns at the edge where the transfer happened.
  task automatic send_item(input in_item_t it);
    if (items_sent + CALM_TAIL < item_goal && $urandom_range(99) < idle_pct) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 13)) @(posedge clk);
    end
    start <= 1'b1;
    in_item <= it;
    @(posedge clk);
    while (busy) @(posedge clk);
    if (it.action == ACT_LOAD_X) x_loaded[it.column] = 1'b1;
    else if (it.action == ACT_LOAD_Y) y_loaded[it.column] = 1'b1;
    if (it.action != ACT_UNUSED) items_sent++;
  endtask

  // Stop sending until every queued row sum has come out, plus pipeline settle time.
  task automatic wait_for_sums();
    int unsigned waited;
    waited = 0;
    start <= 1'b0;
    do begin
      @(posedge clk);
      waited++;
    end while (sums_pending != 0 && waited < DRAIN_LIMIT);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic [1:0] idx, input logic [SMV_PDATA_W-1:0] data);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 2'b00};
    pwdata <= data;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    @(posedge clk);
    if (idx == REG_SPLIT_MODE) split_on = data[0];
    else if (idx == REG_SPLIT_COLUMN) split_col = data[SMV_COL_W-1:0];
  endtask

  task automatic set_mode(input bit split, input logic [SMV_COL_W-1:0] col,
                          input logic [SMV_VAL_W-1:0] piv);
    write_reg(REG_SPLIT_MODE, SMV_PDATA_W'(split));
    write_reg(REG_SPLIT_COLUMN, SMV_PDATA_W'(col));
    write_reg(REG_PIVOT_VALUE, piv);
  endtask

  // One matrix row in order; occasionally a heavy row of extreme values that saturates,
  // an ignored action-3 transfer, or an entry with a stray row index.
  task automatic send_random_row();
    int unsigned          len;
    bit                   heavy;
    logic [SMV_COL_W-1:0] col;
    logic [SMV_VAL_W-1:0] val;
    logic [SMV_ROW_W-1:0] row;
    heavy = ($urandom_range(99) < 10);
    len = heavy ? $urandom_range(3, 6) : $urandom_range(1, 6);
    next_row = ($urandom_range(9) == 0) ? SMV_ROW_W'($urandom()) : next_row + 1'b1;
    col = pick_column();
    val = $urandom_range(1) ? 32'h8000_0000 : 32'h7FFF_FFFF;
    if (heavy && !(split_on && col == split_col))
      send_item(make_item(store_for(col), col, next_row,
                          $urandom_range(1) ? 32'h8000_0000 : 32'h7FFF_FFFF, 1'b0));
    for (int k = 0; k < len; k++) begin
      if ($urandom_range(32) == 0)
        send_item(make_item(ACT_UNUSED, SMV_COL_W'($urandom()), SMV_ROW_W'($urandom()),
                            $urandom(), 1'($urandom_range(1))));
      row = ($urandom_range(32) == 0) ? SMV_ROW_W'($urandom()) : next_row;
      if (!heavy) begin
        col = pick_column();
        val = pick_value();
        if (len == 1 && $urandom_range(3) == 0) val = '0;  // empty row from the feeder
      end
      if (!vec_ready(col))
        send_item(make_item(store_for(col), col, row, pick_value(), 1'($urandom_range(1))));
      send_item(make_item(ACT_NONZERO, col, row, val, k == len - 1));
    end
  endtask

  task automatic run_random_phase(input int unsigned quota);
    int unsigned stop_at;
    stop_at = items_sent + quota;
    window_base = split_col - SMV_COL_W'(16);
    while (items_sent < stop_at) begin
      if (items_sent + CALM_TAIL < item_goal && $urandom_range(49) == 0)
        wait_for_sums();
      if ($urandom_range(19) == 0) idle_pct = (idle_pct == 0) ? 30 : 0;
      repeat ($urandom_range(2))
        send_item(make_item($urandom_range(1) ? ACT_LOAD_Y : ACT_LOAD_X, pick_column(),
                            SMV_ROW_W'($urandom()), pick_value(), 1'($urandom_range(1))));
      send_random_row();
    end
    wait_for_sums();
  endtask

  initial begin
    int unsigned quota;
    quota = RANDOM_ITEMS / 6;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    // plain mode; split column and pivot must have no effect
    set_mode(1'b0, 10'd512, 32'h1234_5678);

    send_item(make_item(ACT_LOAD_X, 10'd0, 16'd0, 32'h8000_0000, 1'b0));
    send_item(make_item(ACT_LOAD_X, 10'd1023, 16'hFFFF, 32'h7FFF_FFFF, 1'b0));
    send_item(make_item(ACT_LOAD_X, 10'd1, 16'd0, 32'h0001_0000, 1'b1));
    send_item(make_item(ACT_LOAD_X, 10'd2, 16'd0, 32'h0000_0001, 1'b0));
    send_item(make_item(ACT_LOAD_Y, 10'd1023, 16'd0, 32'h8000_0000, 1'b1));
    send_item(make_item(ACT_LOAD_Y, 10'd0, 16'd0, 32'hFFFF_FFFF, 1'b0));
    send_item(make_item(ACT_UNUSED, 10'd5, 16'd7, 32'h7FFF_FFFF, 1'b1));
    // three min*min products overflow upward
    send_item(make_item(ACT_NONZERO, 10'd0, 16'd0, 32'h8000_0000, 1'b0));
    send_item(make_item(ACT_NONZERO, 10'd0, 16'd0, 32'h8000_0000, 1'b0));
    send_item(make_item(ACT_NONZERO, 10'd0, 16'd0, 32'h8000_0000, 1'b1));
    send_item(make_item(ACT_NONZERO, 10'd1, 16'd1, 32'h7FFF_FFFF, 1'b1));
    // three min*max products overflow downward, top row index
    send_item(make_item(ACT_NONZERO, 10'd1023, 16'hFFFF, 32'h8000_0000, 1'b0));
    send_item(make_item(ACT_NONZERO, 10'd1023, 16'hFFFF, 32'h8000_0000, 1'b0));
    send_item(make_item(ACT_NONZERO, 10'd1023, 16'hFFFF, 32'h8000_0000, 1'b1));
    // -1 lsb times 1 lsb floors to -1
    send_item(make_item(ACT_NONZERO, 10'd2, 16'd2, 32'hFFFF_FFFF, 1'b1));
    send_item(make_item(ACT_NONZERO, 10'd1, 16'd3, 32'h0000_0000, 1'b1));
    wait_for_sums();

    // split at column 0: pivot there, y above
    set_mode(1'b1, 10'd0, 32'h8000_0000);
    send_item(make_item(ACT_NONZERO, 10'd0, 16'd4, 32'h8000_0000, 1'b0));
    send_item(make_item(ACT_NONZERO, 10'd1023, 16'd4, 32'h7FFF_FFFF, 1'b1));
    wait_for_sums();

    // split at the last column: x below, pivot at 1023
    set_mode(1'b1, 10'd1023, 32'h7FFF_FFFF);
    send_item(make_item(ACT_NONZERO, 10'd1023, 16'd5, 32'h7FFF_FFFF, 1'b0));
    send_item(make_item(ACT_NONZERO, 10'd0, 16'd5, 32'h8000_0000, 1'b1));
    wait_for_sums();

    item_goal = items_sent + RANDOM_ITEMS;
    next_row = 16'd6;
    set_mode(1'b0, 10'd300, $urandom());
    run_random_phase(quota);
    set_mode(1'b1, SMV_COL_W'($urandom()), $urandom());
    run_random_phase(quota);
    set_mode(1'b1, 10'd0, 32'h0000_0000);
    run_random_phase(quota);
    set_mode(1'b1, 10'd1023, 32'h8000_0000);
    run_random_phase(quota);
    set_mode(1'b1, SMV_COL_W'($urandom()), 32'h7FFF_FFFF);
    run_random_phase(quota);
    set_mode(1'b0, 10'd1023, 32'h0000_0000);
    run_random_phase(item_goal - items_sent);

    if (mismatch_count == 0 && sums_pending == 0)
      $display("RESULT: OK");
    else
      $display("RESULT: ERROR");
    $finish;
  end

  initial begin
    #3_000_000;
    $display("RESULT: ERROR");
    $finish;
  end

endmodule

// ===== files.f =====
+incdir+rtl
rtl/smv_pkg.sv
rtl/sparse_matrix_vector_multiply_unit.sv
dv/smv_row_sum_checker.sv
dv/tb_top.sv
